// ----- hdl/frustum_cell_classify_top_macros.svh -----
// Assertion macros shared by the frustum cell classifier checkers.
`ifndef FRUSTUM_CELL_CLASSIFY_TOP_MACROS_SVH
`define FRUSTUM_CELL_CLASSIFY_TOP_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define FCC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define FCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/fcc_pkg.sv -----
// Shared types, widths and helpers of the frustum cell classifier.
package fcc_pkg;

    // Octree and plane set size
    localparam int DEEPEST_LEVEL = 15;
    localparam int PLANE_COUNT   = 6;
    localparam int REG_COUNT     = 6;

    // Field widths
    localparam int COORD_W   = 15;
    localparam int DEPTH_W   = 4;
    localparam int COEF_W    = 16;
    localparam int PLANE_W   = 64;
    localparam int CLASS_W   = 2;
    localparam int REG_IDX_W = 3;
    localparam int SHIFT_W   = $clog2(DEEPEST_LEVEL + 1);

    // Datapath widths: n*pos, n*pos + n, sum of three, shifted sum plus offset
    localparam int PROD_W = COEF_W + COORD_W;
    localparam int TERM_W = PROD_W + 1;
    localparam int SUM_W  = TERM_W + 2;
    localparam int ACC_W  = SUM_W + DEEPEST_LEVEL + 1;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_OUTSIDE   = 2'd0,
        CLASS_INTERSECT = 2'd1,
        CLASS_INSIDE    = 2'd2
    } t_class;

    typedef logic signed [COEF_W-1:0] t_coef;

    // Coefficient 'which' of a packed plane: 0 nx, 1 ny, 2 nz, 3 d
    function automatic t_coef plane_coef(input logic [PLANE_W-1:0] word,
                                         input int unsigned which);
        return t_coef'(word[which*COEF_W +: COEF_W]);
    endfunction

endpackage

// ----- hdl/frustum_cell_classify_top.sv -----
// Top level of the frustum cell classifier: plane registers and test pipeline.
//
// Classifies one octree cell (x, y, z, depth) against the plane set as
// outside, intersect or inside, using the p/n-vertex corner test.
// Request channel: i_start with i_cell_x/y/z/depth; a request is taken at
// a rising edge where i_start is high and o_busy is low. o_busy is high
// only while reset is held, so a request can be taken every cycle.
// Result channel: o_valid pulses for one cycle with o_cell_class; the
// receiver cannot stall, results come in request order.
// Pipeline: a request passes the input register, product register,
// per-plane sign register and result register in that order. Throughput:
// one cell per cycle, set by the 18 lane multipliers n*pos that work on
// every cell in parallel.
// Planes: write port i_cfg_we / i_cfg_idx / i_cfg_data; index 0..5 picks a
// plane, other indexes are dropped. Write only while no request is in
// flight.
// Reset: synchronous, active low; clears the planes (every cell is then
// inside) and empties the pipeline.
module frustum_cell_classify_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [fcc_pkg::COORD_W-1:0]     i_cell_x,
    input  logic [fcc_pkg::COORD_W-1:0]     i_cell_y,
    input  logic [fcc_pkg::COORD_W-1:0]     i_cell_z,
    input  logic [fcc_pkg::DEPTH_W-1:0]     i_cell_depth,
    input  logic                            i_cfg_we,
    input  logic [fcc_pkg::REG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fcc_pkg::PLANE_W-1:0]     i_cfg_data,
    output logic                            o_valid,
    output logic [fcc_pkg::CLASS_W-1:0]     o_cell_class
);
    import fcc_pkg::*;

    // Plane registers
    logic [PLANE_W-1:0] r_plane [REG_COUNT];
    logic [PLANE_W-1:0] plane_w [PLANE_COUNT];
    t_coef              coef_n  [PLANE_COUNT][3];
    t_coef              coef_d  [PLANE_COUNT];

    // Stage 1: captured request
    logic                      r_s1_vld;
    logic [COORD_W-1:0]        r_s1_pos [3];
    logic [SHIFT_W-1:0]        r_s1_shift;
    logic [SHIFT_W-1:0]        n_s1_shift;

    // Stage 2: lane products n*pos
    logic                       r_s2_vld;
    logic signed [PROD_W-1:0]   r_s2_prod [PLANE_COUNT][3];
    logic signed [PROD_W:0]     n_s2_prod [PLANE_COUNT][3];
    logic [SHIFT_W-1:0]         r_s2_shift;

    // Stage 3: per-plane corner signs
    logic                       r_s3_vld;
    logic [PLANE_COUNT-1:0]     r_s3_pass_p;
    logic [PLANE_COUNT-1:0]     r_s3_pass_n;
    logic [PLANE_COUNT-1:0]     n_s3_pass_p;
    logic [PLANE_COUNT-1:0]     n_s3_pass_n;

    // Stage 4: result register
    logic                       r_out_vld;
    t_class                     r_out_class;
    t_class                     n_out_class;

    assign o_busy = ~i_rst_n;

    // Plane register writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                r_plane[i] <= '0;
            end
        end else if (i_cfg_we &&
                     ({1'b0, i_cfg_idx} < (REG_IDX_W + 1)'(REG_COUNT))) begin
            r_plane[i_cfg_idx] <= i_cfg_data;
        end
    end

    // Planes without a register read as all zero and always pass
    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
        if (p < REG_COUNT) begin : g_reg
            assign plane_w[p] = r_plane[p];
        end else begin : g_zero
            assign plane_w[p] = '0;
        end
    end

    // Unpack coefficients
    always_comb begin
        for (int p = 0; p < PLANE_COUNT; p++) begin
            for (int a = 0; a < 3; a++) begin
                coef_n[p][a] = plane_coef(plane_w[p], a);
            end
            coef_d[p] = plane_coef(plane_w[p], 3);
        end
    end

    // Depth to corner shift, depth clamped at the deepest level
    always_comb begin
        if (int'(i_cell_depth) >= DEEPEST_LEVEL) begin
            n_s1_shift = '0;
        end else begin
            n_s1_shift = SHIFT_W'(DEEPEST_LEVEL - int'(i_cell_depth));
        end
    end

    // Stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_start;
        end
        r_s1_pos[0] <= i_cell_x;
        r_s1_pos[1] <= i_cell_y;
        r_s1_pos[2] <= i_cell_z;
        r_s1_shift  <= n_s1_shift;
    end

    // Lane products: the far corner adds n once more, so one product per axis
    always_comb begin
        for (int p = 0; p < PLANE_COUNT; p++) begin
            for (int a = 0; a < 3; a++) begin
                n_s2_prod[p][a] = coef_n[p][a] * $signed({1'b0, r_s1_pos[a]});
            end
        end
    end

    // Stage 2 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        for (int p = 0; p < PLANE_COUNT; p++) begin
            for (int a = 0; a < 3; a++) begin
                r_s2_prod[p][a] <= n_s2_prod[p][a][PROD_W-1:0];
            end
        end
        r_s2_shift <= r_s1_shift;
    end

    // Per plane: sum both corners, scale by cell size, add d, test sign
    logic signed [TERM_W-1:0] term_p [PLANE_COUNT][3];
    logic signed [TERM_W-1:0] term_n [PLANE_COUNT][3];
    logic signed [SUM_W-1:0]  sum_p  [PLANE_COUNT];
    logic signed [SUM_W-1:0]  sum_n  [PLANE_COUNT];
    logic signed [ACC_W-1:0]  acc_p  [PLANE_COUNT];
    logic signed [ACC_W-1:0]  acc_n  [PLANE_COUNT];
    logic signed [ACC_W-1:0]  d_off  [PLANE_COUNT];

    always_comb begin
        for (int p = 0; p < PLANE_COUNT; p++) begin
            for (int a = 0; a < 3; a++) begin
                // p-vertex takes the far side where n >= 0, n-vertex where n <= 0
                if (coef_n[p][a] >= 0) begin
                    term_p[p][a] = TERM_W'(r_s2_prod[p][a]) + TERM_W'(coef_n[p][a]);
                end else begin
                    term_p[p][a] = TERM_W'(r_s2_prod[p][a]);
                end
                if (coef_n[p][a] <= 0) begin
                    term_n[p][a] = TERM_W'(r_s2_prod[p][a]) + TERM_W'(coef_n[p][a]);
                end else begin
                    term_n[p][a] = TERM_W'(r_s2_prod[p][a]);
                end
            end
            sum_p[p] = SUM_W'(term_p[p][0]) + SUM_W'(term_p[p][1]) + SUM_W'(term_p[p][2]);
            sum_n[p] = SUM_W'(term_n[p][0]) + SUM_W'(term_n[p][1]) + SUM_W'(term_n[p][2]);
            d_off[p] = ACC_W'(coef_d[p]) <<< DEEPEST_LEVEL;
            acc_p[p] = (ACC_W'(sum_p[p]) <<< r_s2_shift) + d_off[p];
            acc_n[p] = (ACC_W'(sum_n[p]) <<< r_s2_shift) + d_off[p];
            n_s3_pass_p[p] = ~acc_p[p][ACC_W-1];
            n_s3_pass_n[p] = ~acc_n[p][ACC_W-1];
        end
    end

    // Stage 3 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
        r_s3_pass_p <= n_s3_pass_p;
        r_s3_pass_n <= n_s3_pass_n;
    end

    // Any failing p-vertex means outside, else any failing n-vertex partial
    always_comb begin
        if (!(&r_s3_pass_p)) begin
            n_out_class = CLASS_OUTSIDE;
        end else if (!(&r_s3_pass_n)) begin
            n_out_class = CLASS_INTERSECT;
        end else begin
            n_out_class = CLASS_INSIDE;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_s3_vld;
        end
        r_out_class <= n_out_class;
    end

    assign o_valid      = r_out_vld;
    assign o_cell_class = r_out_class;

endmodule

// ----- hdl/fcc_check.sv -----
// Port-level checker for the frustum cell classifier, bound to the top level.
`include "frustum_cell_classify_top_macros.svh"

module fcc_check (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        o_busy,
    input  logic                        o_valid,
    input  logic [fcc_pkg::CLASS_W-1:0] o_cell_class
);
    import fcc_pkg::*;

    // Every accepted request yields a result
    `FCC_ASSERT_NEXT(a_req_gives_result, i_start && !o_busy, ##3 o_valid, "request lost")

    // No result without an earlier accepted request
    `FCC_ASSERT_IMP(a_result_has_req, o_valid, $past(i_start, 4) && !$past(o_busy, 4), "result invented")

    // A result carries one of the three classes
    `FCC_ASSERT_IMP(a_class_legal, o_valid, o_cell_class == CLASS_OUTSIDE || o_cell_class == CLASS_INTERSECT || o_cell_class == CLASS_INSIDE, "bad class")

endmodule

bind frustum_cell_classify_top fcc_check u_fcc_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_start      (i_start),
    .o_busy       (o_busy),
    .o_valid      (o_valid),
    .o_cell_class (o_cell_class)
);

// ----- verif/tb_top.sv -----
// Self-checking testbench of the frustum cell classifier: directed and random frusta.
`timescale 1ns / 1ps

module tb_top;
    import fcc_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int PIPE_DEPTH      = 4;
    localparam int DRAIN_CYCLES    = PIPE_DEPTH + 4;
    localparam int MAX_GAP         = 19;
    localparam int RANDOM_PHASES   = 9;
    localparam int CELLS_PER_PHASE = 100;
    localparam int REPORT_LIMIT    = 10;
    localparam int TIMEOUT_CYCLES  = 400000;
    localparam int REG_SLOTS       = 2 ** REG_IDX_W;

    // Q3.12 coefficients
    localparam logic [COEF_W-1:0] COEF_ZERO    = 16'h0000;
    localparam logic [COEF_W-1:0] COEF_ONE     = 16'h1000;
    localparam logic [COEF_W-1:0] COEF_NEG_ONE = 16'hF000;
    localparam logic [COEF_W-1:0] COEF_NEG_QTR = 16'hFC00;
    localparam logic [COEF_W-1:0] COEF_3_QTR   = 16'h0C00;
    localparam logic [COEF_W-1:0] COEF_MAX     = 16'h7FFF;
    localparam logic [COEF_W-1:0] COEF_MIN     = 16'h8000;
    localparam logic [COEF_W-1:0] COEF_NEG_LSB = 16'hFFFF;

    localparam logic [COORD_W-1:0] COORD_MAX = '1;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_start;
    logic                   o_busy;
    logic [COORD_W-1:0]     i_cell_x;
    logic [COORD_W-1:0]     i_cell_y;
    logic [COORD_W-1:0]     i_cell_z;
    logic [DEPTH_W-1:0]     i_cell_depth;
    logic                   i_cfg_we;
    logic [REG_IDX_W-1:0]   i_cfg_idx;
    logic [PLANE_W-1:0]     i_cfg_data;
    logic                   o_valid;
    logic [CLASS_W-1:0]     o_cell_class;

    // Plane set as the block should hold it, and the set a test wants loaded next
    logic [PLANE_W-1:0] plane_regs    [REG_COUNT];
    logic [PLANE_W-1:0] staged_planes [REG_COUNT];

    t_class expected_classes [$];
    t_class want_class;
    int     mismatch_count;

    frustum_cell_classify_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_cell_x     (i_cell_x),
        .i_cell_y     (i_cell_y),
        .i_cell_z     (i_cell_z),
        .i_cell_depth (i_cell_depth),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_cell_class (o_cell_class)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    // Packs one plane as {d, nz, ny, nx}
    function automatic logic [PLANE_W-1:0] pack_plane(input logic [COEF_W-1:0] nx,
                                                      input logic [COEF_W-1:0] ny,
                                                      input logic [COEF_W-1:0] nz,
                                                      input logic [COEF_W-1:0] d);
        return {d, nz, ny, nx};
    endfunction

    // p/n-vertex test of one cell against the held planes, exact in 64 bits
    function automatic t_class classify_cell(input logic [COORD_W-1:0] x,
                                             input logic [COORD_W-1:0] y,
                                             input logic [COORD_W-1:0] z,
                                             input logic [DEPTH_W-1:0] depth);
        longint  pos [3];
        shortint n [3];
        shortint d;
        longint  acc_far, acc_near, c_far, c_near;
        int      shift;
        bit      partial;
        partial = 1'b0;
        pos[0]  = longint'(x);
        pos[1]  = longint'(y);
        pos[2]  = longint'(z);
        shift   = (int'(depth) > DEEPEST_LEVEL) ? 0 : DEEPEST_LEVEL - int'(depth);
        for (int p = 0; p < PLANE_COUNT && p < REG_COUNT; p++) begin
            for (int a = 0; a < 3; a++)
                n[a] = plane_regs[p][a*COEF_W +: COEF_W];
            d        = plane_regs[p][3*COEF_W +: COEF_W];
            acc_far  = longint'(d) * (longint'(1) << DEEPEST_LEVEL);
            acc_near = acc_far;
            for (int a = 0; a < 3; a++) begin
                // far corner where the normal is >= 0, near corner where <= 0
                c_far    = (pos[a] + ((n[a] >= 0) ? 1 : 0)) << shift;
                c_near   = (pos[a] + ((n[a] <= 0) ? 1 : 0)) << shift;
                acc_far  = acc_far + longint'(n[a]) * c_far;
                acc_near = acc_near + longint'(n[a]) * c_near;
            end
            if (acc_far < 0)
                return CLASS_OUTSIDE;
            if (acc_near < 0)
                partial = 1'b1;
        end
        return partial ? CLASS_INTERSECT : CLASS_INSIDE;
    endfunction

    // Result check, then capture of the request taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                if (expected_classes.size() == 0) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: cell class %0d with no request pending",
                                 $realtime, o_cell_class);
                end else begin
                    want_class = expected_classes.pop_front();
                    if (o_cell_class !== want_class) begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("%0t: cell class mismatch: expected %0d, got %0d",
                                     $realtime, want_class, o_cell_class);
                    end
                end
            end
            if (i_start && !o_busy)
                expected_classes = {expected_classes,
                                    classify_cell(i_cell_x, i_cell_y,
                                                  i_cell_z, i_cell_depth)};
        end
    end

    // Drops start, lets every pending result come back, then a few quiet cycles
    task automatic wait_idle();
        i_start <= 1'b0;
        while (expected_classes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Loads the staged planes, then pokes the unused indexes, which must be dropped
    task automatic program_planes();
        wait_idle();
        for (int r = 0; r < REG_COUNT; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= REG_IDX_W'(r);
            i_cfg_data <= staged_planes[r];
            plane_regs[r] = staged_planes[r];
            @(posedge i_clk);
        end
        for (int r = REG_COUNT; r < REG_SLOTS; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= REG_IDX_W'(r);
            i_cfg_data <= {$urandom, $urandom};
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // One request, after an idle gap if gap is nonzero; start stays high until the next gap
    task automatic send_cell(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic [COORD_W-1:0] z, input logic [DEPTH_W-1:0] depth,
                             input int gap);
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start      <= 1'b1;
        i_cell_x     <= x;
        i_cell_y     <= y;
        i_cell_z     <= z;
        i_cell_depth <= depth;
        @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
    endtask

    // Planes all zero after reset: every cell is inside
    task automatic test_reset_state();
        send_cell('0, '0, '0, '0, 0);
        send_cell(COORD_MAX, COORD_MAX, COORD_MAX, DEPTH_MAX, 0);
        send_cell(15'h5555, 15'h2AAA, '0, 4'd10, 3);
        send_cell(15'h2AAA, 15'h5555, COORD_MAX, 4'd5, 0);
    endtask

    // Axis-aligned box 0.25..0.75 on each axis; zero normal components throughout
    task automatic test_box_planes();
        staged_planes[0] = pack_plane(COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_NEG_QTR);
        staged_planes[1] = pack_plane(COEF_NEG_ONE, COEF_ZERO, COEF_ZERO, COEF_3_QTR);
        staged_planes[2] = pack_plane(COEF_ZERO, COEF_ONE, COEF_ZERO, COEF_NEG_QTR);
        staged_planes[3] = pack_plane(COEF_ZERO, COEF_NEG_ONE, COEF_ZERO, COEF_3_QTR);
        staged_planes[4] = pack_plane(COEF_ZERO, COEF_ZERO, COEF_ONE, COEF_NEG_QTR);
        staged_planes[5] = pack_plane(COEF_ZERO, COEF_ZERO, COEF_NEG_ONE, COEF_3_QTR);
        program_planes();
        send_cell('0, '0, '0, 4'd0, 0);                     // root straddles the box
        send_cell(15'd1, 15'd1, 15'd1, 4'd2, 0);            // exactly inside
        send_cell(15'd0, 15'd1, 15'd1, 4'd2, 2);            // touches the x face
        send_cell(15'd0, 15'd3, 15'd3, 4'd3, 0);            // clear of the box
        send_cell(15'd1, 15'd1, 15'd1, 4'd1, 0);            // upper octant, partial
        send_cell(COORD_MAX, 15'd0, 15'd0, 4'd0, 1);        // position past 2^D-1
        send_cell(15'd16384, 15'd16384, 15'd16384, DEPTH_MAX, 0);
        send_cell(COORD_MAX, COORD_MAX, COORD_MAX, DEPTH_MAX, 0);
    endtask

    // Coefficients at their limits, cells at the corners of the space
    task automatic test_extreme_coefficients();
        staged_planes[0] = '1;
        staged_planes[1] = pack_plane(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        staged_planes[2] = pack_plane(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        staged_planes[3] = pack_plane(COEF_MIN, COEF_MAX, COEF_ZERO, COEF_MAX);
        staged_planes[4] = pack_plane(COEF_MAX, COEF_MIN, COEF_NEG_LSB, COEF_ZERO);
        staged_planes[5] = '0;
        program_planes();
        send_cell('0, '0, '0, '0, 0);
        send_cell(COORD_MAX, COORD_MAX, COORD_MAX, DEPTH_MAX, 0);
        // other corners with the all-ones and most-negative planes swapped out
        staged_planes[0] = pack_plane(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        staged_planes[1] = pack_plane(COEF_MIN, COEF_ZERO, COEF_ZERO, COEF_MAX);
        program_planes();
        send_cell(COORD_MAX, '0, COORD_MAX, '0, 0);
        send_cell('0, COORD_MAX, '0, DEPTH_MAX, 0);
        send_cell(15'd1, 15'd0, 15'd0, DEPTH_MAX, 0);
    endtask

    // Random frusta around a random point, half of the cells near that point
    task automatic test_random_frusta();
        int cx, cy, cz, nx, ny, nz, dot, dval, sel, shift, gap;
        logic [COORD_W-1:0] x, y, z;
        logic [DEPTH_W-1:0] depth;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            cx = $urandom_range(0, 32767);
            cy = $urandom_range(0, 32767);
            cz = $urandom_range(0, 32767);
            for (int r = 0; r < REG_COUNT; r++) begin
                sel = $urandom_range(0, 9);
                if (sel == 0) begin
                    staged_planes[r] = {$urandom, $urandom};
                end else if (sel == 1) begin
                    staged_planes[r] = '0;
                end else begin
                    // normal within +-1.0, plane offset so the center sits inside
                    nx = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 8192)) - 4096;
                    ny = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 8192)) - 4096;
                    nz = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 8192)) - 4096;
                    dot  = nx * cx + ny * cy + nz * cz;
                    dval = -(dot >>> DEEPEST_LEVEL) + int'($urandom_range(0, 2048));
                    staged_planes[r] = pack_plane(COEF_W'(nx), COEF_W'(ny),
                                                  COEF_W'(nz), COEF_W'(dval));
                end
            end
            program_planes();
            for (int i = 0; i < CELLS_PER_PHASE; i++) begin
                sel = $urandom_range(0, 9);
                if (sel < 5) begin
                    depth = DEPTH_W'($urandom_range(2, 15));
                    shift = DEEPEST_LEVEL - int'(depth);
                    x = COORD_W'((cx >> shift) + int'($urandom_range(0, 4)) - 2);
                    y = COORD_W'((cy >> shift) + int'($urandom_range(0, 4)) - 2);
                    z = COORD_W'((cz >> shift) + int'($urandom_range(0, 4)) - 2);
                end else if (sel < 9) begin
                    depth = DEPTH_W'($urandom_range(0, 15));
                    x = COORD_W'($urandom_range(0, (1 << depth) - 1));
                    y = COORD_W'($urandom_range(0, (1 << depth) - 1));
                    z = COORD_W'($urandom_range(0, (1 << depth) - 1));
                end else begin
                    depth = DEPTH_W'($urandom);
                    x = COORD_W'($urandom);
                    y = COORD_W'($urandom);
                    z = COORD_W'($urandom);
                end
                // back to back, fully random gaps, or rare bursts of idle
                case (phase % 3)
                    0: gap = 0;
                    1: gap = $urandom_range(0, MAX_GAP);
                    default: gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_GAP) : 0;
                endcase
                send_cell(x, y, z, depth, gap);
            end
        end
    endtask

    initial begin
        mismatch_count = 0;
        for (int r = 0; r < REG_COUNT; r++)
            plane_regs[r] = '0;
        i_rst_n      <= 1'b0;
        i_start      <= 1'b0;
        i_cell_x     <= '0;
        i_cell_y     <= '0;
        i_cell_z     <= '0;
        i_cell_depth <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= '0;
        i_cfg_data   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_box_planes();
        test_extreme_coefficients();
        test_random_frusta();
        wait_idle();

        if (mismatch_count == 0 && expected_classes.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #(2 * CLK_HALF * TIMEOUT_CYCLES);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
